// ===== hw/rtl/bgpw_pkg.sv =====
// Shared types, codes and constant tables for the bitmap glyph pixel writer.
`timescale 1ns / 1ps

package bgpw_pkg;

  typedef enum logic [1:0] {
    MODE_DRAW    = 2'd0,
    MODE_GLYPH   = 2'd1,
    MODE_PALETTE = 2'd2,
    MODE_PIXEL   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic req_draws;
    logic vis_empty;
    logic vis_last;
    logic out_free;
  } status_t;

  localparam int MODE_W    = 2;
  localparam int CODE_W    = 7;
  localparam int POS_W     = 6;
  localparam int XY_W      = 7;
  localparam int CI_W      = 4;
  localparam int MASK_W    = 15;
  localparam int COLOR_W   = 32;
  localparam int COORD_W   = 11;
  localparam int BIT_W     = 4;
  localparam int GLYPH_AW  = 7;

  localparam int S_DATA_W  = 80;
  localparam int M_DATA_W  = 48;

  localparam int CODE_LSB  = 0;
  localparam int POS_LSB   = CODE_LSB + CODE_W;
  localparam int BX_LSB    = POS_LSB + POS_W;
  localparam int BY_LSB    = BX_LSB + XY_W;
  localparam int CI_LSB    = BY_LSB + XY_W;
  localparam int MASK_LSB  = CI_LSB + CI_W;
  localparam int PVAL_LSB  = MASK_LSB + MASK_W;

  localparam logic [CODE_W-1:0] GLYPH_FIRST = 7'h20;
  localparam logic [CODE_W-1:0] GLYPH_LAST  = 7'h7e;
  localparam int GLYPH_SLOTS = 95;

  localparam logic [1:0] BIT_COL [0:14] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
  };

  localparam logic [2:0] BIT_ROW [0:14] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
  };

endpackage

// ===== hw/rtl/bitmap_glyph_pixel_writer.sv =====
// Top level of the bitmap glyph pixel writer: 3x5 text and pixel drawing.
`timescale 1ns / 1ps

// Requests arrive on the s_ group, one beat each; s_tuser carries the mode
// (draw character, load glyph, load palette entry, set pixel). Pixel writes
// leave on the m_ group, one beat per framebuffer write, m_tlast on the
// final write of a request. Loads are taken while idle and the block is
// ready again in the next cycle. A draw or set pixel reads the glyph and
// palette memories on acceptance (registered reads), builds the clipped
// mask in the fetch state, then scans one beat per visible pixel, clearing
// one mask bit each cycle while the output register is free. A request
// that is fully clipped or non-printable emits no write and returns to
// idle. The output register lets the last beat wait while the next
// request is taken. When the output register is full and m_tready is low
// the scan holds on the pending beat.
// Reset clears the sequencer and the output valid; the glyph store and the
// palette hold no defined value until loaded.

module bitmap_glyph_pixel_writer #(
  parameter int SCREEN_W     = 128,
  parameter int SCREEN_H     = 128,
  parameter int PALETTE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code[6:0], char_position[12:7], base_x[19:13], base_y[26:20],
  // color_index[30:27], glyph_mask[45:31], palette_value[77:46], zero[79:78]
  input  logic [79:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_x[6:0], pixel_y[13:7], pixel_color[45:14], zero[47:46]
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  bgpw_pkg::cmd_t    cmd;
  bgpw_pkg::status_t status;

  bgpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bgpw_datapath #(
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .in_mode  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_emit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("beat emitted into a full output register");

  a_no_emit_idle : assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.emit)
    else $error("beat emitted while taking requests");

  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.vis_last |=> s_tready)
    else $error("not ready after the final write of a request");
`endif

endmodule

// ===== hw/rtl/bgpw_ctrl.sv =====
// Request sequencer: accept, fetch glyph and color, then scan out beats.
`timescale 1ns / 1ps

module bgpw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bgpw_pkg::status_t status,
  output bgpw_pkg::cmd_t    cmd
);

  bgpw_pkg::state_t state;
  bgpw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgpw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      bgpw_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && status.req_draws) begin
          state_next = bgpw_pkg::ST_FETCH;
        end
      end
      bgpw_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = bgpw_pkg::ST_SCAN;
      end
      bgpw_pkg::ST_SCAN: begin
        if (status.vis_empty) begin
          state_next = bgpw_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.vis_last) begin
            state_next = bgpw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = bgpw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bgpw_datapath.sv =====
// Glyph and palette memories, clip mask, bit scan and output register.
`timescale 1ns / 1ps

module bgpw_datapath #(
  parameter int SCREEN_W     = 128,
  parameter int SCREEN_H     = 128,
  parameter int PALETTE_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bgpw_pkg::cmd_t                    cmd,
  output bgpw_pkg::status_t                 status,
  input  logic [bgpw_pkg::S_DATA_W-1:0]     in_data,
  input  logic [bgpw_pkg::MODE_W-1:0]       in_mode,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [bgpw_pkg::M_DATA_W-1:0]     m_tdata,
  output logic                              m_tlast
);

  localparam int PAL_DEPTH = (PALETTE_SIZE < 16) ? PALETTE_SIZE : 16;
  localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

  logic [bgpw_pkg::CODE_W-1:0]  code;
  logic [bgpw_pkg::POS_W-1:0]   pos;
  logic [bgpw_pkg::XY_W-1:0]    bx;
  logic [bgpw_pkg::XY_W-1:0]    by;
  logic [bgpw_pkg::CI_W-1:0]    ci;
  logic [bgpw_pkg::MASK_W-1:0]  mask;
  logic [bgpw_pkg::COLOR_W-1:0] pval;
  logic                         printable;
  logic                         ci_ok;
  logic [bgpw_pkg::GLYPH_AW-1:0] glyph_addr;

  assign code = in_data[bgpw_pkg::CODE_LSB +: bgpw_pkg::CODE_W];
  assign pos  = in_data[bgpw_pkg::POS_LSB +: bgpw_pkg::POS_W];
  assign bx   = in_data[bgpw_pkg::BX_LSB +: bgpw_pkg::XY_W];
  assign by   = in_data[bgpw_pkg::BY_LSB +: bgpw_pkg::XY_W];
  assign ci   = in_data[bgpw_pkg::CI_LSB +: bgpw_pkg::CI_W];
  assign mask = in_data[bgpw_pkg::MASK_LSB +: bgpw_pkg::MASK_W];
  assign pval = in_data[bgpw_pkg::PVAL_LSB +: bgpw_pkg::COLOR_W];

  assign printable  = (code >= bgpw_pkg::GLYPH_FIRST) && (code <= bgpw_pkg::GLYPH_LAST);
  assign ci_ok      = 32'(ci) < PALETTE_SIZE;
  assign glyph_addr = code - bgpw_pkg::GLYPH_FIRST;

  assign status.req_draws = (in_mode == bgpw_pkg::MODE_DRAW) ||
                            (in_mode == bgpw_pkg::MODE_PIXEL);

  logic [bgpw_pkg::MASK_W-1:0]  glyph_mem [0:bgpw_pkg::GLYPH_SLOTS-1];
  logic [bgpw_pkg::COLOR_W-1:0] pal_mem [0:PAL_DEPTH-1];
  logic [bgpw_pkg::MASK_W-1:0]  glyph_q;
  logic [bgpw_pkg::COLOR_W-1:0] pal_q;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_mode == bgpw_pkg::MODE_GLYPH && printable) begin
      glyph_mem[glyph_addr] <= mask;
    end
    if (cmd.accept) begin
      glyph_q <= glyph_mem[glyph_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_mode == bgpw_pkg::MODE_PALETTE && ci_ok) begin
      pal_mem[ci[PAL_AW-1:0]] <= pval;
    end
    if (cmd.accept) begin
      pal_q <= pal_mem[ci[PAL_AW-1:0]];
    end
  end

  logic                          pixel_r;
  logic                          printable_r;
  logic                          ci_ok_r;
  logic [bgpw_pkg::COORD_W-1:0]  x0;
  logic [bgpw_pkg::COORD_W-1:0]  y0;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel_r     <= in_mode == bgpw_pkg::MODE_PIXEL;
      printable_r <= printable;
      ci_ok_r     <= ci_ok;
      y0          <= bgpw_pkg::COORD_W'(by);
      if (in_mode == bgpw_pkg::MODE_PIXEL) begin
        x0 <= bgpw_pkg::COORD_W'(bx);
      end else begin
        x0 <= bgpw_pkg::COORD_W'(bx) + bgpw_pkg::COORD_W'({pos, 2'b00});
      end
    end
  end

  logic [2:0]                   col_ok;
  logic [4:0]                   row_ok;
  logic [bgpw_pkg::MASK_W-1:0]  src;
  logic [bgpw_pkg::MASK_W-1:0]  vis_fetch;
  logic [bgpw_pkg::MASK_W-1:0]  vis;
  logic [bgpw_pkg::MASK_W-1:0]  vis_rest;
  logic [bgpw_pkg::COLOR_W-1:0] color;
  logic [bgpw_pkg::BIT_W-1:0]   idx;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_ok[c] = (x0 + bgpw_pkg::COORD_W'(c)) < bgpw_pkg::COORD_W'(SCREEN_W);
    end
    for (int r = 0; r < 5; r++) begin
      row_ok[r] = (y0 + bgpw_pkg::COORD_W'(r)) < bgpw_pkg::COORD_W'(SCREEN_H);
    end
    if (pixel_r) begin
      src = bgpw_pkg::MASK_W'(1);
    end else if (printable_r) begin
      src = glyph_q;
    end else begin
      src = '0;
    end
    for (int b = 0; b < bgpw_pkg::MASK_W; b++) begin
      vis_fetch[b] = src[b] & col_ok[bgpw_pkg::BIT_COL[b]] & row_ok[bgpw_pkg::BIT_ROW[b]];
    end
  end

  always_comb begin
    idx = '0;
    for (int b = bgpw_pkg::MASK_W - 1; b >= 0; b--) begin
      if (vis[b]) begin
        idx = bgpw_pkg::BIT_W'(b);
      end
    end
  end

  assign vis_rest         = vis & (vis - bgpw_pkg::MASK_W'(1));
  assign status.vis_empty = vis == '0;
  assign status.vis_last  = vis_rest == '0;
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      vis   <= vis_fetch;
      color <= ci_ok_r ? pal_q : '0;
    end else if (cmd.emit) begin
      vis <= vis_rest;
    end
  end

  logic [bgpw_pkg::XY_W-1:0] px;
  logic [bgpw_pkg::XY_W-1:0] py;

  assign px = bgpw_pkg::XY_W'(x0 + bgpw_pkg::COORD_W'(bgpw_pkg::BIT_COL[idx]));
  assign py = bgpw_pkg::XY_W'(y0 + bgpw_pkg::COORD_W'(bgpw_pkg::BIT_ROW[idx]));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, color, py, px};
      m_tlast <= status.vis_last;
    end
  end

endmodule

// ===== bench/bitmap_glyph_pixel_writer_test.sv =====
// Self-checking bench for the bitmap glyph pixel writer: requests in, predicted writes out.
`timescale 1ns / 1ps

module bitmap_glyph_pixel_writer_test;

  localparam int SCR_W = 128;
  localparam int SCR_H = 128;
  localparam int PAL_N = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    bgpw_pkg::mode_t mode;
    logic [6:0]  code;
    logic [5:0]  pos;
    logic [6:0]  bx;
    logic [6:0]  by;
    logic [3:0]  ci;
    logic [14:0] mask;
    logic [31:0] pval;
  } request_t;

  typedef struct packed {
    logic [6:0]  x;
    logic [6:0]  y;
    logic [31:0] color;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  logic [14:0] glyph_mem [bgpw_pkg::GLYPH_SLOTS];
  bit          glyph_ok [bgpw_pkg::GLYPH_SLOTS];
  logic [31:0] pal_mem [PAL_N];
  bit          pal_ok [PAL_N];
  pixel_t      pending_writes [$];

  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  bitmap_glyph_pixel_writer #(
    .SCREEN_W    (SCR_W),
    .SCREEN_H    (SCR_H),
    .PALETTE_SIZE(PAL_N)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [79:0] pack_request(request_t r);
    return {2'b00, r.pval, r.mask, r.ci, r.by, r.bx, r.pos, r.code};
  endfunction

  function automatic void predict_writes(request_t r);
    pixel_t      run [$];
    pixel_t      w;
    logic [14:0] g;
    logic [31:0] col;
    int          x0;
    int          px;
    int          py;
    col = (int'(r.ci) < PAL_N) ? pal_mem[r.ci] : '0;
    case (r.mode)
      bgpw_pkg::MODE_GLYPH: begin
        if (r.code >= bgpw_pkg::GLYPH_FIRST && r.code <= bgpw_pkg::GLYPH_LAST) begin
          glyph_mem[r.code - bgpw_pkg::GLYPH_FIRST] = r.mask;
          glyph_ok[r.code - bgpw_pkg::GLYPH_FIRST] = 1'b1;
        end
      end
      bgpw_pkg::MODE_PALETTE: begin
        if (int'(r.ci) < PAL_N) begin
          pal_mem[r.ci] = r.pval;
          pal_ok[r.ci] = 1'b1;
        end
      end
      bgpw_pkg::MODE_PIXEL: begin
        if (int'(r.bx) < SCR_W && int'(r.by) < SCR_H) begin
          w.x = r.bx;
          w.y = r.by;
          w.color = col;
          w.last = 1'b1;
          pending_writes.push_back(w);
        end
      end
      default: begin
        if (r.code >= bgpw_pkg::GLYPH_FIRST && r.code <= bgpw_pkg::GLYPH_LAST) begin
          g = glyph_mem[r.code - bgpw_pkg::GLYPH_FIRST];
          x0 = int'(r.bx) + 4 * int'(r.pos);
          for (int b = 0; b < 15; b++) begin
            px = x0 + b % 3;
            py = int'(r.by) + b / 3;
            if (g[b] && px < SCR_W && py < SCR_H) begin
              w.x = 7'(px);
              w.y = 7'(py);
              w.color = col;
              w.last = 1'b0;
              run.push_back(w);
            end
          end
          if (run.size() > 0) begin
            run[run.size() - 1].last = 1'b1;
          end
          foreach (run[i]) begin
            pending_writes.push_back(run[i]);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [6:0] pick_loaded_code();
    logic [6:0] c;
    do begin
      c = 7'(bgpw_pkg::GLYPH_FIRST + 7'($urandom_range(bgpw_pkg::GLYPH_SLOTS - 1)));
    end while (!glyph_ok[c - bgpw_pkg::GLYPH_FIRST]);
    return c;
  endfunction

  function automatic logic [3:0] pick_loaded_color();
    logic [3:0] c;
    do begin
      c = 4'($urandom_range(PAL_N - 1));
    end while (!pal_ok[c]);
    return c;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       sel;
    r.mode = bgpw_pkg::MODE_DRAW;
    r.code = 7'($urandom);
    r.pos  = 6'($urandom);
    r.bx   = 7'($urandom);
    r.by   = 7'($urandom);
    r.ci   = 4'($urandom);
    r.mask = 15'($urandom);
    r.pval = $urandom;
    sel = int'($urandom_range(99));
    if (sel < 45) begin
      r.code = pick_loaded_code();
      r.ci = pick_loaded_color();
      if ($urandom_range(9) < 7) begin
        r.pos = 6'($urandom_range((127 - int'(r.bx)) / 4));
      end
      if ($urandom_range(4) != 0) begin
        r.by = 7'($urandom_range(123));
      end
    end else if (sel < 55) begin
      r.code = ($urandom_range(1) != 0) ? 7'h7f : 7'($urandom_range(31));
      r.ci = pick_loaded_color();
    end else if (sel < 70) begin
      r.mode = bgpw_pkg::MODE_GLYPH;
    end else if (sel < 80) begin
      r.mode = bgpw_pkg::MODE_PALETTE;
    end else begin
      r.mode = bgpw_pkg::MODE_PIXEL;
      r.ci = pick_loaded_color();
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    while (int'($urandom_range(99)) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.mode;
    s_tdata  <= pack_request(r);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_writes(r);
  endtask

  task automatic send_fields(input bgpw_pkg::mode_t mode, input logic [6:0] code,
                             input logic [5:0] pos, input logic [6:0] bx,
                             input logic [6:0] by, input logic [3:0] ci,
                             input logic [14:0] mask, input logic [31:0] pval);
    request_t r;
    r = '{mode: mode, code: code, pos: pos, bx: bx, by: by, ci: ci, mask: mask, pval: pval};
    send_request(r);
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    send_fields(bgpw_pkg::MODE_PALETTE, 7'($urandom), 6'($urandom), 7'($urandom),
                7'($urandom), 4'd0, 15'($urandom), 32'h0000_0000);
    send_fields(bgpw_pkg::MODE_PALETTE, 7'($urandom), 6'($urandom), 7'($urandom),
                7'($urandom), 4'd15, 15'($urandom), 32'hffff_ffff);
    send_fields(bgpw_pkg::MODE_PALETTE, 7'($urandom), 6'($urandom), 7'($urandom),
                7'($urandom), 4'd5, 15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_GLYPH, bgpw_pkg::GLYPH_FIRST, 6'($urandom), 7'($urandom),
                7'($urandom), 4'($urandom), 15'h0000, $urandom);
    send_fields(bgpw_pkg::MODE_GLYPH, bgpw_pkg::GLYPH_LAST, 6'($urandom), 7'($urandom),
                7'($urandom), 4'($urandom), 15'h7fff, $urandom);
    send_fields(bgpw_pkg::MODE_GLYPH, 7'h41, 6'($urandom), 7'($urandom), 7'($urandom),
                4'($urandom), 15'h2bea, $urandom);
    // non-printable loads are dropped
    send_fields(bgpw_pkg::MODE_GLYPH, 7'h1f, 6'($urandom), 7'($urandom), 7'($urandom),
                4'($urandom), 15'h7fff, $urandom);
    send_fields(bgpw_pkg::MODE_GLYPH, 7'h7f, 6'($urandom), 7'($urandom), 7'($urandom),
                4'($urandom), 15'h7fff, $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_FIRST, 6'd0, 7'd10, 7'd10, 4'd0,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_LAST, 6'd0, 7'd0, 7'd0, 4'd15,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_LAST, 6'd0, 7'd127, 7'd20, 4'd5,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_LAST, 6'd31, 7'd0, 7'd40, 4'd15,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_LAST, 6'd63, 7'd127, 7'd0, 4'd15,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, 7'h41, 6'd2, 7'd3, 7'd127, 4'd5, 15'($urandom),
                $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, bgpw_pkg::GLYPH_LAST, 6'd1, 7'd5, 7'd124, 4'd0,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, 7'h41, 6'd63, 7'd127, 7'd127, 4'd5, 15'($urandom),
                $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, 7'h00, 6'd0, 7'd0, 7'd0, 4'd0, 15'($urandom),
                $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, 7'h1f, 6'd1, 7'd8, 7'd8, 4'd15, 15'($urandom),
                $urandom);
    send_fields(bgpw_pkg::MODE_DRAW, 7'h7f, 6'd1, 7'd8, 7'd8, 4'd5, 15'($urandom),
                $urandom);
    send_fields(bgpw_pkg::MODE_PIXEL, 7'($urandom), 6'($urandom), 7'd0, 7'd0, 4'd0,
                15'($urandom), $urandom);
    send_fields(bgpw_pkg::MODE_PIXEL, 7'($urandom), 6'($urandom), 7'd127, 7'd127, 4'd15,
                15'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(input int count, input int src_idle, input int sink_stall);
    idle_pct = src_idle;
    stall_pct = sink_stall;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_output_backpressure();
    request_t r;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (16) begin
      r = random_request();
      r.mode = bgpw_pkg::MODE_DRAW;
      r.code = bgpw_pkg::GLYPH_LAST;
      r.ci = pick_loaded_color();
      r.bx = 7'($urandom_range(100));
      r.pos = 6'($urandom_range(6));
      r.by = 7'($urandom_range(120));
      send_request(r);
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 9;
    stall_pct = 9;
    repeat (6) send_request(random_request());
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (6) send_request(random_request());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  always @(posedge clk) begin : write_checker
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write x=%0d y=%0d", m_tdata[6:0], m_tdata[13:7]));
      end else begin
        want = pending_writes.pop_front();
        if (m_tdata[6:0] !== want.x) begin
          report_mismatch($sformatf("pixel_x %0d, want %0d", m_tdata[6:0], want.x));
        end
        if (m_tdata[13:7] !== want.y) begin
          report_mismatch($sformatf("pixel_y %0d, want %0d", m_tdata[13:7], want.y));
        end
        if (m_tdata[45:14] !== want.color) begin
          report_mismatch($sformatf("pixel_color %h, want %h", m_tdata[45:14], want.color));
        end
        if (m_tdata[47:46] !== 2'b00) begin
          report_mismatch($sformatf("pad bits %b, want 00", m_tdata[47:46]));
        end
        if (m_tlast !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(15, 0, 0);
    test_random_traffic(15, 58, 0);
    test_random_traffic(15, 0, 58);
    test_random_traffic(15, 9, 9);
    test_output_backpressure();
    test_drain_pause();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
